>>> src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property holds at every clock edge outside reset.
`define MVRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mvrs assertion failed");
// When ante holds, cons holds in the following cycle.
`define MVRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvrs assertion failed");
`else
`define MVRS_ASSERT(lbl, clk, rst, prop)
`define MVRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> src/mvrs_pkg.sv
`default_nettype none

package mvrs_pkg;

  localparam int ADDR_W       = 48;
  localparam int COUNT_W      = 32;
  localparam int TIME_W       = 48;
  localparam int DEV_W        = 4;
  localparam int PAIRS_W      = 4;
  localparam int PNUM_W       = 5;
  localparam int PRIM_W       = 50;
  localparam int RESULT_LIMIT = 16;
  localparam int DIV_CNT_W    = 6;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 64;

  localparam logic [ADDR_W-1:0]  CAPACITY_RESET = 48'd1073741824;
  localparam logic [PAIRS_W-1:0] PAIRS_RESET    = 4'd2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FAIL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_PAIRS    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_LEN,
    ST_LOOK,
    ST_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic fail_wr;
    logic div_start;
    logic len_calc;
    logic look;
    logic emit;
    logic finish;
  } ctl_t;

  typedef struct packed {
    cmd_t op;
    logic rem_zero;
    logic div_done;
    logic out_free;
    logic has_second;
    logic more_pieces;
  } status_t;

endpackage

`default_nettype wire

>>> src/mvrs_if.sv
`default_nettype none

interface mvrs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [47:0] volume_address;
  logic [31:0] byte_count;
  logic [47:0] request_time;
  logic [3:0] failed_device;

  modport source (
    output valid, cmd, volume_address, byte_count, request_time, failed_device,
    input  ready
  );
  modport sink (
    input  valid, cmd, volume_address, byte_count, request_time, failed_device,
    output ready
  );
endinterface

interface mvrs_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  device_index;
  logic [47:0] device_address;
  logic [31:0] piece_bytes;
  logic [4:0]  piece_number;
  logic        to_mirror;
  logic        no_live_copy;
  logic        out_of_range;
  logic        last;

  modport source (
    output valid, device_index, device_address, piece_bytes, piece_number,
           to_mirror, no_live_copy, out_of_range, last,
    input  ready
  );
  modport sink (
    input  valid, device_index, device_address, piece_bytes, piece_number,
           to_mirror, no_live_copy, out_of_range, last,
    output ready
  );
endinterface

`default_nettype wire

>>> src/mvrs_cfg.sv
`default_nettype none

module mvrs_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mvrs_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [mvrs_pkg::PDATA_W-1:0]      pwdata,
  output logic      [mvrs_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  output logic      [mvrs_pkg::ADDR_W-1:0]       device_capacity,
  output logic      [mvrs_pkg::PAIRS_W-1:0]      mirror_pairs
);

  mvrs_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = mvrs_pkg::reg_idx_t'(paddr[3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_capacity <= mvrs_pkg::CAPACITY_RESET;
      mirror_pairs    <= mvrs_pkg::PAIRS_RESET;
    end else if (wr) begin
      unique case (idx)
        mvrs_pkg::REG_CAPACITY: device_capacity <= pwdata[mvrs_pkg::ADDR_W-1:0];
        mvrs_pkg::REG_PAIRS:    mirror_pairs    <= pwdata[mvrs_pkg::PAIRS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mvrs_pkg::REG_CAPACITY: prdata[mvrs_pkg::ADDR_W-1:0]  = device_capacity;
      mvrs_pkg::REG_PAIRS:    prdata[mvrs_pkg::PAIRS_W-1:0] = mirror_pairs;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/mvrs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mvrs_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [mvrs_pkg::ADDR_W-1:0]  dividend,
  input  wire logic [mvrs_pkg::ADDR_W-1:0]  divisor,
  output logic                              done,
  output logic      [mvrs_pkg::ADDR_W-1:0]  quotient,
  output logic      [mvrs_pkg::ADDR_W-1:0]  remainder
);

  localparam int W = mvrs_pkg::ADDR_W;

  logic                               busy;
  logic [mvrs_pkg::DIV_CNT_W-1:0]     cnt;
  logic [W-1:0]                       quo;
  logic [W-1:0]                       part;
  logic [W-1:0]                       den;
  logic [W:0]                         trial;
  logic [W:0]                         diff;
  logic                               ge;
  logic [W-1:0]                       part_next;

  assign trial     = {part, quo[W-1]};
  assign diff      = trial - {1'b0, den};
  assign ge        = trial >= {1'b0, den};
  assign part_next = ge ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + mvrs_pkg::DIV_CNT_W'(1);
        if (cnt == mvrs_pkg::DIV_CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      part <= '0;
      den  <= divisor;
    end else if (busy) begin
      quo  <= {quo[W-2:0], ge};
      part <= part_next;
    end
  end

  assign quotient  = quo;
  assign remainder = part;

endmodule

`default_nettype wire

>>> src/mvrs_dp.sv
`default_nettype none
`include "assert_macros.svh"

module mvrs_dp #(
  parameter int MAX_DEVICES = 16,
  parameter int MAX_PIECES  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mvrs_pkg::ctl_t                ctl,
  output mvrs_pkg::status_t                  status,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [mvrs_pkg::ADDR_W-1:0]   in_address,
  input  wire logic [mvrs_pkg::COUNT_W-1:0]  in_count,
  input  wire logic [mvrs_pkg::TIME_W-1:0]   in_time,
  input  wire logic [mvrs_pkg::DEV_W-1:0]    in_dev,
  input  wire logic [mvrs_pkg::ADDR_W-1:0]   device_capacity,
  input  wire logic [mvrs_pkg::PAIRS_W-1:0]  mirror_pairs,
  mvrs_res_if.source                         res
);

  localparam int IDX_W  = $clog2(MAX_DEVICES);
  localparam int PCNT_W = $clog2(MAX_PIECES + 1);
  localparam int AW     = mvrs_pkg::ADDR_W;
  localparam int CW     = mvrs_pkg::COUNT_W;
  localparam int TW     = mvrs_pkg::TIME_W;
  localparam int PW     = mvrs_pkg::PRIM_W;
  localparam int NW     = mvrs_pkg::PNUM_W;

  mvrs_pkg::cmd_t    op;
  logic [AW-1:0]     addr;
  logic [CW-1:0]     rem;
  logic [TW-1:0]     now;
  logic [mvrs_pkg::DEV_W-1:0] fdev;
  logic              rfp;
  logic [PW-1:0]     prim;
  logic [AW-1:0]     off;
  logic [CW-1:0]     len;
  logic              clipped;
  logic              pd;
  logic              md;
  logic              sub;
  logic [NW-1:0]     n;
  logic [PCNT_W-1:0] pieces;

  logic              failed [MAX_DEVICES];
  logic [TW-1:0]     ftime  [MAX_DEVICES];
  logic [TW-1:0]     time_p;
  logic [TW-1:0]     time_m;

  logic [AW-1:0]     cap_eff;
  logic [mvrs_pkg::PAIRS_W-1:0] pairs_eff;
  logic [PW-1:0]     mirr;
  logic              prim_in;
  logic              mirr_in;
  logic              fail_ok;
  logic [AW-1:0]     span;
  logic              p_down;
  logic              m_down;

  logic              div_done;
  logic [AW-1:0]     div_q;
  logic [AW-1:0]     div_r;

  logic              tgt_mirror;
  logic              nolive;
  logic              has_second;
  logic              more_pieces;
  logic              emit_last;
  logic              first_down;
  logic              other_down;

  assign cap_eff   = (device_capacity == '0) ? AW'(1) : device_capacity;
  assign pairs_eff = (mirror_pairs == '0) ? mvrs_pkg::PAIRS_W'(1) : mirror_pairs;
  assign mirr      = prim + PW'(pairs_eff);
  assign prim_in   = prim < PW'(MAX_DEVICES);
  assign mirr_in   = mirr < PW'(MAX_DEVICES);
  assign fail_ok   = int'(fdev) < MAX_DEVICES;
  assign span      = cap_eff - off;

  assign p_down = prim_in && failed[prim[IDX_W-1:0]] && (time_p <= now);
  assign m_down = mirr_in && failed[mirr[IDX_W-1:0]] && (time_m <= now);

  mvrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (addr),
    .divisor   (cap_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // target selection for the result in flight
  always_comb begin
    first_down = rfp ? pd : md;
    other_down = rfp ? md : pd;
    tgt_mirror = 1'b0;
    nolive     = 1'b0;
    has_second = 1'b0;
    if (op == mvrs_pkg::CMD_READ) begin
      tgt_mirror = !rfp;
      if (first_down && other_down) begin
        nolive = 1'b1;
      end else if (first_down) begin
        tgt_mirror = rfp;
      end
    end else if (sub) begin
      tgt_mirror = 1'b1;
    end else if (pd && md) begin
      nolive = 1'b1;
    end else if (pd) begin
      tgt_mirror = 1'b1;
    end else begin
      has_second = !md && (n < NW'(mvrs_pkg::RESULT_LIMIT - 1));
    end
    more_pieces = !clipped && (int'(pieces) + 1 < MAX_PIECES)
                  && (n < NW'(mvrs_pkg::RESULT_LIMIT - 1));
    emit_last   = !has_second && !more_pieces;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op     <= mvrs_pkg::cmd_t'(in_cmd);
      addr   <= in_address;
      rem    <= in_count;
      now    <= in_time;
      fdev   <= in_dev;
      n      <= '0;
      pieces <= '0;
      sub    <= 1'b0;
    end
    if (div_done) begin
      prim <= PW'(div_q);
      off  <= div_r;
    end
    if (ctl.len_calc) begin
      if (span >= AW'(rem)) begin
        len     <= rem;
        clipped <= 1'b1;
      end else begin
        len     <= span[CW-1:0];
        clipped <= 1'b0;
      end
    end
    if (ctl.look) begin
      pd <= p_down;
      md <= m_down;
    end
    if (ctl.emit) begin
      n <= n + NW'(1);
      if (has_second) begin
        sub <= 1'b1;
      end else begin
        sub    <= 1'b0;
        prim   <= prim + PW'(1);
        off    <= '0;
        rem    <= rem - len;
        pieces <= pieces + PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rfp <= 1'b1;
    end else if (ctl.finish && op == mvrs_pkg::CMD_READ) begin
      rfp <= !rfp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DEVICES; i++) begin
        failed[i] <= 1'b0;
      end
    end else if (ctl.fail_wr && fail_ok) begin
      failed[IDX_W'(fdev)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fail_wr && fail_ok) begin
      ftime[IDX_W'(fdev)] <= now;
    end
    time_p <= ftime[prim[IDX_W-1:0]];
    time_m <= ftime[mirr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctl.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res.device_index   <= tgt_mirror ? mirr[mvrs_pkg::DEV_W-1:0]
                                       : prim[mvrs_pkg::DEV_W-1:0];
      res.device_address <= off;
      res.piece_bytes    <= len;
      res.piece_number   <= n + NW'(1);
      res.to_mirror      <= tgt_mirror;
      res.no_live_copy   <= nolive;
      res.out_of_range   <= prim >= PW'(pairs_eff);
      res.last           <= emit_last;
    end
  end

  always_comb begin
    status.op          = op;
    status.rem_zero    = (rem == '0);
    status.div_done    = div_done;
    status.out_free    = !res.valid || res.ready;
    status.has_second  = has_second;
    status.more_pieces = more_pieces;
  end

  `MVRS_ASSERT(a_emit_room, clk, rst, ctl.emit |-> (!res.valid || res.ready))
  `MVRS_ASSERT_NEXT(a_last_ends, clk, rst, ctl.emit && emit_last, !ctl.emit)
  `MVRS_ASSERT(a_pnum_nonzero, clk, rst, res.valid |-> (res.piece_number != '0))

endmodule

`default_nettype wire

>>> src/mvrs_ctrl.sv
`default_nettype none

module mvrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mvrs_pkg::status_t  status,
  output mvrs_pkg::ctl_t          ctl
);

  mvrs_pkg::state_t state;
  mvrs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mvrs_pkg::ST_IDLE: begin
        if (in_valid) state_next = mvrs_pkg::ST_DECODE;
      end
      mvrs_pkg::ST_DECODE: begin
        unique case (status.op)
          mvrs_pkg::CMD_READ, mvrs_pkg::CMD_WRITE: begin
            state_next = status.rem_zero ? mvrs_pkg::ST_FINISH : mvrs_pkg::ST_DIV;
          end
          default: state_next = mvrs_pkg::ST_IDLE;
        endcase
      end
      mvrs_pkg::ST_DIV: begin
        if (status.div_done) state_next = mvrs_pkg::ST_LEN;
      end
      mvrs_pkg::ST_LEN:  state_next = mvrs_pkg::ST_LOOK;
      mvrs_pkg::ST_LOOK: state_next = mvrs_pkg::ST_EMIT;
      mvrs_pkg::ST_EMIT: begin
        if (status.out_free) begin
          priority if (status.has_second) begin
            state_next = mvrs_pkg::ST_EMIT;
          end else if (status.more_pieces) begin
            state_next = mvrs_pkg::ST_LEN;
          end else begin
            state_next = mvrs_pkg::ST_FINISH;
          end
        end
      end
      mvrs_pkg::ST_FINISH: state_next = mvrs_pkg::ST_IDLE;
      default: state_next = mvrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      mvrs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      mvrs_pkg::ST_DECODE: begin
        ctl.fail_wr   = (status.op == mvrs_pkg::CMD_FAIL);
        ctl.div_start = ((status.op == mvrs_pkg::CMD_READ) ||
                         (status.op == mvrs_pkg::CMD_WRITE)) && !status.rem_zero;
      end
      mvrs_pkg::ST_DIV:    ;
      mvrs_pkg::ST_LEN:    ctl.len_calc = 1'b1;
      mvrs_pkg::ST_LOOK:   ctl.look = 1'b1;
      mvrs_pkg::ST_EMIT:   ctl.emit = status.out_free;
      mvrs_pkg::ST_FINISH: ctl.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/mirrored_volume_request_splitter_top.sv
// Mirrored volume request splitter.
// Input channel req carries one transaction per read, write or device failure
// event; output channel res carries one transaction per device piece.
// A read or write is cut at device-capacity boundaries; reads go to one copy
// (alternating primary/mirror per read, falling back if the copy has failed),
// writes go to every live copy. Results of a request come in order, with last
// set on the final one. Empty requests and unused commands give no results.
// Processing: a decode step, 48 bit-serial divider steps and a quotient
// capture, then per piece a length step, a failure lookup and an emit; the
// second copy of a write piece takes one more emit.
// Only one transaction is in flight; req.ready is high only when idle.
// The output register holds a result until res.ready; a stall holds back
// the next emit and nothing is dropped.
// Reset (rst, synchronous): capacity 1 GiB, 2 mirror pairs, no failed devices,
// the next read goes to the primary copy.
// Config: APB, device_capacity at 0x0, mirror_pairs at 0x8; write only idle.
`default_nettype none

module mirrored_volume_request_splitter_top #(
  parameter int MAX_DEVICES = 16,
  parameter int MAX_PIECES  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mvrs_req_if.sink                           req,
  mvrs_res_if.source                         res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mvrs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mvrs_pkg::PDATA_W-1:0]  pwdata,
  output logic      [mvrs_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  logic [mvrs_pkg::ADDR_W-1:0]  device_capacity;
  logic [mvrs_pkg::PAIRS_W-1:0] mirror_pairs;
  logic                         in_ready;
  mvrs_pkg::ctl_t               ctl;
  mvrs_pkg::status_t            status;

  assign req.ready = in_ready;

  mvrs_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .device_capacity (device_capacity),
    .mirror_pairs    (mirror_pairs)
  );

  mvrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .ctl      (ctl)
  );

  mvrs_dp #(
    .MAX_DEVICES (MAX_DEVICES),
    .MAX_PIECES  (MAX_PIECES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .status          (status),
    .in_cmd          (req.cmd),
    .in_address      (req.volume_address),
    .in_count        (req.byte_count),
    .in_time         (req.request_time),
    .in_dev          (req.failed_device),
    .device_capacity (device_capacity),
    .mirror_pairs    (mirror_pairs),
    .res             (res)
  );

endmodule

`default_nettype wire
